/* design/ipc_pkg.sv */
package ipc_pkg;

    localparam int NUM_PROTOCOLS = 256;
    localparam int PROTO_W       = 8;
    localparam int VALUE_W       = 64;
    localparam int OFFSET_W      = 6;

    localparam logic [OFFSET_W-1:0] ETH_HI_POS    = 6'd12;
    localparam logic [OFFSET_W-1:0] ETH_LO_POS    = 6'd13;
    localparam logic [OFFSET_W-1:0] PROTO_POS     = 6'd23;
    localparam logic [OFFSET_W-1:0] MIN_FRAME_LEN = 6'd34;

    localparam logic [15:0]        ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_ICMP     = 8'd1;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_COUNT   = 1'b1
    } t_kind;

    // Outcome of the frame parser for the byte currently offered.
    typedef struct packed {
        logic               count_en;
        logic               drop;
        logic [PROTO_W-1:0] proto;
    } t_parse;

    // Request from the input side to the counter stage.
    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic               count_en;
        logic               drop;
        logic [PROTO_W-1:0] addr;
    } t_req;

endpackage

/* design/ipc_ram.sv */
module ipc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ipc_parser.sv */
module ipc_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    output ipc_pkg::t_parse         o_parse
);
    import ipc_pkg::*;

    logic [OFFSET_W-1:0] r_offset;
    logic [OFFSET_W-1:0] n_offset;
    logic                r_eth_ok;
    logic                n_eth_ok;
    logic [PROTO_W-1:0]  r_proto;
    logic [PROTO_W-1:0]  n_proto;

    // State after this byte, before the end-of-frame clear.
    always_comb begin
        n_eth_ok = r_eth_ok;
        n_proto  = r_proto;
        if (r_offset == ETH_HI_POS) begin
            n_eth_ok = (i_byte == ETHERTYPE_IPV4[15:8]);
        end else if (r_offset == ETH_LO_POS) begin
            n_eth_ok = r_eth_ok && (i_byte == ETHERTYPE_IPV4[7:0]);
        end else if (r_offset == PROTO_POS) begin
            n_proto = i_byte;
        end
        n_offset = (r_offset < MIN_FRAME_LEN) ? r_offset + OFFSET_W'(1) : r_offset;
    end

    always_comb begin
        o_parse.count_en = (n_offset >= MIN_FRAME_LEN) && n_eth_ok;
        o_parse.drop     = o_parse.count_en && (n_proto == PROTO_ICMP);
        o_parse.proto    = n_proto;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_eth_ok <= 1'b0;
            r_proto  <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_offset <= '0;
                r_eth_ok <= 1'b0;
                r_proto  <= '0;
            end else begin
                r_offset <= n_offset;
                r_eth_ok <= n_eth_ok;
                r_proto  <= n_proto;
            end
        end
    end

endmodule

/* design/ipc_counter.sv */
module ipc_counter #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ipc_pkg::t_req              i_req,
    output logic                       o_req_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ipc_pkg::t_kind             o_out_kind,
    output logic                       o_out_verdict,
    output logic [ipc_pkg::VALUE_W-1:0] o_out_value
);
    import ipc_pkg::*;

    // Entry valid bits stand in for the reset clear of the counter memory.
    logic [NUM_PROTOCOLS-1:0] r_vbit;

    logic               r_s1_valid;
    t_kind              r_s1_kind;
    logic               r_s1_count;
    logic               r_s1_drop;
    logic [PROTO_W-1:0] r_s1_addr;
    logic               r_s1_vbit;

    // Most recent write, used to bypass the memory when it is not yet visible.
    logic                   r_lw_vld;
    logic [PROTO_W-1:0]     r_lw_addr;
    logic [COUNT_WIDTH-1:0] r_lw_data;

    logic                   r_out_valid;
    t_kind                  r_out_kind;
    logic                   r_out_verdict;
    logic [VALUE_W-1:0]     r_out_value;

    logic                   rd_en;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] base;
    logic [COUNT_WIDTH-1:0] incr;
    logic                   advance;
    logic                   wr_en;

    assign advance     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_req_ready = !r_s1_valid || advance;
    // The read is issued only when the request actually enters the stage, so a
    // stalled stage keeps its read data.
    assign rd_en       = o_req_ready && i_req.valid &&
                         ((i_req.kind == KIND_COUNT) || i_req.count_en);
    assign wr_en       = advance && r_s1_count;

    ipc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_PROTOCOLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (incr),
        .i_re    (rd_en),
        .i_raddr (i_req.addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        if (r_lw_vld && (r_lw_addr == r_s1_addr)) begin
            base = r_lw_data;
        end else if (r_s1_vbit) begin
            base = rd_data;
        end else begin
            base = '0;
        end
        incr = base + COUNT_WIDTH'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbit      <= '0;
            r_s1_valid  <= 1'b0;
            r_lw_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vbit[r_s1_addr] <= 1'b1;
                r_lw_vld          <= 1'b1;
            end
            if (o_req_ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req.valid) begin
            r_s1_kind  <= i_req.kind;
            r_s1_count <= i_req.count_en;
            r_s1_drop  <= i_req.drop;
            r_s1_addr  <= i_req.addr;
        end
        if (rd_en) begin
            r_s1_vbit <= r_vbit[i_req.addr];
        end
        if (wr_en) begin
            r_lw_addr <= r_s1_addr;
            r_lw_data <= incr;
        end
        if (advance) begin
            r_out_kind    <= r_s1_kind;
            r_out_verdict <= (r_s1_kind == KIND_VERDICT) ? r_s1_drop : 1'b0;
            r_out_value   <= (r_s1_kind == KIND_COUNT) ? VALUE_W'(base) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_verdict = r_out_verdict;
    assign o_out_value   = r_out_value;

    a_no_req_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |-> !o_req_ready)
        else $error("request taken while the counter stage is stalled");

    a_drop_is_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_s1_drop) |-> (r_s1_count && (r_s1_kind == KIND_VERDICT)))
        else $error("drop verdict for a frame that is not counted");

    a_vbit_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_vbit[$past(r_s1_addr)])
        else $error("entry not marked valid after its write");

    a_bypass_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_lw_vld && (r_lw_data == $past(incr))))
        else $error("bypass register lost the latest write");

    a_read_has_no_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_COUNT)) |-> !r_out_verdict)
        else $error("counter read carries a drop verdict");

endmodule

/* design/ipv4_protocol_counter_icmp_drop.sv */
// Channel   Direction  Handshake               Payload
// s (in)    slave      i_s_tvalid / o_s_tready tdata: frame_byte, counter_index;
//                                              tlast: last_byte; tuser: opcode
// m (out)   master     o_m_tvalid / i_m_tready tdata: verdict, counter_value;
//                                              tuser: result_kind
//
// One item is accepted per cycle when o_s_tready is high. A frame byte without the last
// mark only updates the parser registers and gives no result. A last byte or a counter
// read enters the counter stage with a registered read of the counter memory; the move
// into the output register does the increment, write back and result. A bypass of the
// last write covers back-to-back updates of the same counter.
// Reset is synchronous and active low; it clears the parser and the per-entry valid bits,
// so every counter reads as zero afterwards with no clearing pass.
// A stalled output holds the result; the input keeps flowing until both the counter stage
// and the output register are full.
module ipv4_protocol_counter_icmp_drop #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] frame_byte, [15:8] counter_index
    input  logic        i_s_tlast,
    input  logic        i_s_tuser,   // [0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [0] verdict, [64:1] counter_value, [71:65] zero
    output logic        o_m_tuser    // [0] result_kind
);
    import ipc_pkg::*;

    logic               accept;
    t_opcode            opcode;
    t_parse             parse;
    t_req               req;
    t_kind              out_kind;
    logic               out_verdict;
    logic [VALUE_W-1:0] out_value;

    assign opcode = t_opcode'(i_s_tuser);
    assign accept = i_s_tvalid && o_s_tready;

    // The parser sees only frame bytes; a counter read leaves the frame untouched.
    ipc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept && (opcode == OP_FRAME)),
        .i_byte   (i_s_tdata[7:0]),
        .i_last   (i_s_tlast),
        .o_parse  (parse)
    );

    // Only items that give a result are handed to the counter stage.
    always_comb begin
        req.valid    = i_s_tvalid && ((opcode == OP_READ) || i_s_tlast);
        req.kind     = (opcode == OP_READ) ? KIND_COUNT : KIND_VERDICT;
        req.count_en = (opcode == OP_FRAME) && parse.count_en;
        req.drop     = (opcode == OP_FRAME) && parse.drop;
        req.addr     = (opcode == OP_READ) ? i_s_tdata[15:8] : parse.proto;
    end

    ipc_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .o_req_ready   (o_s_tready),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out_kind    (out_kind),
        .o_out_verdict (out_verdict),
        .o_out_value   (out_value)
    );

    assign o_m_tdata = {7'd0, out_value, out_verdict};
    assign o_m_tuser = out_kind;

endmodule

/* dv/ipv4_protocol_counter_icmp_drop_tb.sv */
`timescale 1ns / 1ps

// Stream-level check of the IPv4 protocol counter. Frames go in byte by byte
// with counter reads mixed in. Every accepted item updates a local copy of the
// parser and of the 256 protocol counters. A verdict or a read value from that
// copy is queued, and each result the block hands out must match the oldest
// entry in the queue.
module ipv4_protocol_counter_icmp_drop_tb;
    import ipc_pkg::*;

    localparam int CNT_W          = 64;
    localparam logic [VALUE_W-1:0] COUNT_MASK = {VALUE_W{1'b1}} >> (VALUE_W - CNT_W);
    localparam int N_ITEMS        = 1450;
    localparam int IDLE_LIMIT     = 1000;  // longest gap plus longest stall, several times
    localparam int SETTLE_CYCLES  = 8;     // margin for any stray result after the last expected one
    localparam int MAX_REPORTS    = 50;

    // Common protocol numbers used to steer both frames and reads.
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // One item on the input stream.
    typedef struct {
        t_opcode            op;
        logic [7:0]         fbyte;
        logic               last;
        logic [PROTO_W-1:0] idx;
    } t_item;

    // One result on the output stream.
    typedef struct {
        t_kind              kind;
        logic               drop;
        logic [VALUE_W-1:0] count;
    } t_outcome;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [7:0] frame_byte, [15:8] counter_index
    logic        i_s_tlast  = 1'b0;
    logic        i_s_tuser  = 1'b0; // [0] opcode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;         // [0] verdict, [64:1] counter_value, [71:65] zero
    logic        o_m_tuser;         // [0] result_kind

    t_item    pending_items[$];
    t_outcome outcomes_due[$];

    // Local copy of the parser and the counters.
    logic [OFFSET_W-1:0] frame_off  = '0;
    logic                eth_ok     = 1'b0;
    logic [PROTO_W-1:0]  proto_seen = '0;
    logic [VALUE_W-1:0]  proto_count [NUM_PROTOCOLS] = '{default: '0};

    int n_errors    = 0;
    int idle_cycles = 0;

    ipv4_protocol_counter_icmp_drop #(
        .COUNT_WIDTH(CNT_W)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        n_errors++;
    endtask

    // Applies one accepted item to the local parser and counters and queues
    // the result that it causes, if any.
    task automatic classify_and_count(input t_item it);
        t_outcome res;
        if (it.op == OP_READ) begin
            res.kind  = KIND_COUNT;
            res.drop  = 1'b0;
            res.count = proto_count[it.idx];
            outcomes_due.push_back(res);
        end else begin
            // The EtherType match is built over two bytes; the protocol byte
            // is captured once at its fixed offset.
            if (frame_off == ETH_HI_POS) begin
                eth_ok = (it.fbyte == ETHERTYPE_IPV4[15:8]);
            end else if (frame_off == ETH_LO_POS) begin
                eth_ok = eth_ok && (it.fbyte == ETHERTYPE_IPV4[7:0]);
            end else if (frame_off == PROTO_POS) begin
                proto_seen = it.fbyte;
            end
            if (frame_off < MIN_FRAME_LEN) begin
                frame_off++;
            end
            if (it.last) begin
                res.kind  = KIND_VERDICT;
                res.drop  = 1'b0;
                res.count = '0;
                // Short or non-IPv4 frames pass without being counted.
                if (frame_off >= MIN_FRAME_LEN && eth_ok) begin
                    proto_count[proto_seen] = (proto_count[proto_seen] + 1'b1) & COUNT_MASK;
                    res.drop = (proto_seen == PROTO_ICMP);
                end
                outcomes_due.push_back(res);
                frame_off  = '0;
                eth_ok     = 1'b0;
                proto_seen = '0;
            end
        end
    endtask

    // Protocol numbers are drawn mostly from a small set so that the same
    // counters are hit again and again, with the edges and random ones mixed in.
    function automatic logic [PROTO_W-1:0] pick_proto();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return PROTO_ICMP;
        end else if (r < 60) begin
            return PROTO_TCP;
        end else if (r < 75) begin
            return PROTO_UDP;
        end else if (r < 80) begin
            return 8'd0;
        end else if (r < 85) begin
            return 8'd255;
        end
        return PROTO_W'($urandom_range(0, 255));
    endfunction

    // Unused fields carry random bits so that every input bit toggles.
    task automatic push_byte(input logic [7:0] fbyte, input logic last);
        t_item it;
        it.op    = OP_FRAME;
        it.fbyte = fbyte;
        it.last  = last;
        it.idx   = PROTO_W'($urandom_range(0, 255));
        pending_items.push_back(it);
    endtask

    task automatic push_read(input logic [PROTO_W-1:0] idx);
        t_item it;
        it.op    = OP_READ;
        it.fbyte = 8'($urandom_range(0, 255));
        it.last  = 1'($urandom_range(0, 1));
        it.idx   = idx;
        pending_items.push_back(it);
    endtask

    // A frame of random bytes with the EtherType and the protocol byte placed
    // at their offsets. Reads may be slipped in between its bytes.
    task automatic push_frame(input int len, input logic [15:0] etype,
                              input logic [PROTO_W-1:0] proto, input int read_pct);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < read_pct) begin
                push_read(pick_proto());
            end
            if (k == ETH_HI_POS) begin
                b = etype[15:8];
            end else if (k == ETH_LO_POS) begin
                b = etype[7:0];
            end else if (k == PROTO_POS) begin
                b = proto;
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            push_byte(b, k == len - 1);
        end
    endtask

    // Reset and stimulus. The whole item list is built at time zero, before
    // the first clock edge; the driver then works through it.
    initial begin
        int         r;
        int         len;
        logic [15:0] etype;

        // Counters read as zero after reset, at both ends of the index range.
        push_read(8'd0);
        push_read(8'd255);
        push_read(PROTO_ICMP);
        // A single-byte frame is too short and passes.
        push_frame(1, ETHERTYPE_IPV4, PROTO_ICMP, 0);
        // One byte short of the minimum: passes, not counted.
        push_frame(33, ETHERTYPE_IPV4, PROTO_ICMP, 0);
        push_read(PROTO_ICMP);
        // Minimum-length ICMP frame is dropped and counted.
        push_frame(34, ETHERTYPE_IPV4, PROTO_ICMP, 0);
        push_read(PROTO_ICMP);
        // A UDP frame passes and is counted, with reads in the middle of it.
        push_frame(34, ETHERTYPE_IPV4, PROTO_UDP, 20);
        // Non-IPv4 frames, wrong in either EtherType byte, pass uncounted.
        push_frame(60, 16'h0801, PROTO_ICMP, 0);
        push_frame(40, 16'h1800, PROTO_ICMP, 0);
        push_frame(40, 16'h08ff, PROTO_ICMP, 0);
        // Long frames at the edges of the protocol range.
        push_frame(64, ETHERTYPE_IPV4, 8'd0, 0);
        push_frame(64, ETHERTYPE_IPV4, 8'd255, 0);
        push_frame(80, ETHERTYPE_IPV4, PROTO_ICMP, 0);
        push_read(8'd0);
        push_read(PROTO_ICMP);
        push_read(PROTO_UDP);
        push_read(8'd255);

        // Random part: mostly well-formed IPv4 frames, with short frames,
        // bad EtherTypes and loose counter reads mixed in.
        while (pending_items.size() < N_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                push_read(pick_proto());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    len = $urandom_range(34, 45);
                end else if (r < 85) begin
                    len = $urandom_range(1, 33);
                end else begin
                    len = $urandom_range(46, 80);
                end
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    etype = ETHERTYPE_IPV4;
                end else if (r < 85) begin
                    etype = {ETHERTYPE_IPV4[15:8], 8'($urandom_range(1, 255))};
                end else if (r < 90) begin
                    etype = {8'($urandom_range(0, 255)) ^ 8'h08 | 8'h01, ETHERTYPE_IPV4[7:0]};
                end else begin
                    etype = 16'($urandom_range(0, 16'hffff));
                end
                push_frame(len, etype, pick_proto(), 5);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to go in and every result to come out, then
        // give the block time to show any stray result.
        while (pending_items.size() != 0 || outcomes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Sender: offers items from the pending list in bursts of random length,
    // separated by random gaps. An offered item is held until it is taken.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : drive_items
        logic  offer;
        t_item nxt;
        int    r;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            offer = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                classify_and_count(pending_items.pop_front());
                offer = 1'b0;
                if (burst_left > 0) begin
                    burst_left--;
                end
            end
            if (!offer) begin
                if (burst_left == 0) begin
                    r = $urandom_range(0, 9);
                    burst_left = (r == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
                    r = $urandom_range(0, 9);
                    if (r < 4) begin
                        gap_left = 0;
                    end else if (r < 8) begin
                        gap_left = $urandom_range(1, 4);
                    end else begin
                        gap_left = $urandom_range(10, 25);
                    end
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    nxt       = pending_items[0];
                    offer     = 1'b1;
                    i_s_tdata <= {nxt.idx, nxt.fbyte};
                    i_s_tlast <= nxt.last;
                    i_s_tuser <= nxt.op;
                end
            end
            i_s_tvalid <= offer;
        end
    end

    // Receiver: ready follows its own pattern of steady stretches, short and
    // long stalls, and cycle-by-cycle flicker.
    int   ready_left    = 0;
    logic ready_level   = 1'b1;
    logic ready_flicker = 1'b0;

    always @(posedge i_clk) begin : check_results
        t_outcome exp_res;
        int       r;
        if (o_m_tvalid && i_m_tready) begin
            if (outcomes_due.size() == 0) begin
                report_mismatch("result arrived with nothing expected");
            end else begin
                exp_res = outcomes_due.pop_front();
                if (o_m_tuser !== exp_res.kind) begin
                    report_mismatch($sformatf("result_kind %b, expected %b",
                                              o_m_tuser, exp_res.kind));
                end
                if (o_m_tdata[0] !== exp_res.drop) begin
                    report_mismatch($sformatf("verdict %b, expected %b",
                                              o_m_tdata[0], exp_res.drop));
                end
                if (o_m_tdata[64:1] !== exp_res.count) begin
                    report_mismatch($sformatf("counter_value %0d, expected %0d",
                                              o_m_tdata[64:1], exp_res.count));
                end
                if (o_m_tdata[71:65] !== '0) begin
                    report_mismatch($sformatf("padding bits %b not zero", o_m_tdata[71:65]));
                end
            end
        end

        if (ready_left == 0) begin
            r = $urandom_range(0, 9);
            ready_flicker = 1'b0;
            if (r < 4) begin
                ready_level = 1'b1;
                ready_left  = $urandom_range(1, 40);
            end else if (r < 7) begin
                ready_flicker = 1'b1;
                ready_left    = $urandom_range(1, 20);
            end else if (r < 9) begin
                ready_level = 1'b0;
                ready_left  = $urandom_range(1, 12);
            end else begin
                ready_level = 1'b0;
                ready_left  = $urandom_range(20, 40);
            end
        end
        ready_left--;
        i_m_tready <= ready_flicker ? 1'($urandom_range(0, 1)) : ready_level;
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge i_clk) begin : watchdog
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
